// ----- rtl/sm3_pkg.sv -----
// SM3 hash engine package: constants, types and round helper functions.
// No dependencies; used by every module under rtl.
`default_nettype none

package sm3_pkg;

    localparam int QueueDepth = 4;

    localparam logic [255:0] SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam logic [31:0] T_LOW  = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [5:0]  POS_MASK = 6'h3F;
    localparam logic [5:0]  LEN_OFFSET = 6'd56;

    typedef enum logic
    {
        OP_ABSORB = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    typedef struct packed
    {
        op_t        op;
        logic [7:0] data;
    } item_t;

    function automatic logic [31:0] rol32(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        begin
            d = {x, x} << n;
            rol32 = d[63:32];
        end
    endfunction

    function automatic logic [31:0] perm0(input logic [31:0] x);
        perm0 = x ^ {x[22:0], x[31:23]} ^ {x[14:0], x[31:15]};
    endfunction

    function automatic logic [31:0] perm1(input logic [31:0] x);
        perm1 = x ^ {x[16:0], x[31:17]} ^ {x[8:0], x[31:9]};
    endfunction

endpackage

`default_nettype wire

// ----- rtl/sm3_front.sv -----
// SM3 front end: accepts stream items and queues them for the compression side.
// Depends on sm3_pkg.
`default_nettype none

module sm3_front
    import sm3_pkg::*;
#(
    parameter int DEPTH = QueueDepth
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_ready,
    input  wire item_t in_item,
    output logic       q_valid,
    input  wire logic  q_ready,
    output item_t      q_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    item_t        mem [DEPTH];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign in_ready = (cnt_reg != (AW+1)'(DEPTH));
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = mem[rd_reg];
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sm3_round.sv -----
// SM3 compression unit: one message-expansion step and one round per cycle.
// Depends on sm3_pkg.
`default_nettype none

module sm3_round
    import sm3_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         start,
    input  wire logic [511:0] block,
    input  wire logic [255:0] cv_in,
    output logic              done,
    output logic [255:0]      cv_out
);

    // W window: w_reg[0] = W[j] ... w_reg[15] = W[j+15]
    logic [31:0]  w_reg [16];
    logic [31:0]  a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg;
    logic [255:0] cv_reg;
    logic [5:0]   j_reg;
    logic         busy_reg;

    logic [31:0] w_new, tj, a12, ss1, ss2, ff, gg, tt1, tt2;

    always_comb
    begin
        w_new = perm1(w_reg[0] ^ w_reg[7] ^ rol32(w_reg[13], 5'd15))
              ^ rol32(w_reg[3], 5'd7) ^ w_reg[10];
        tj    = (j_reg < 6'd16) ? T_LOW : T_HIGH;
        a12   = rol32(a_reg, 5'd12);
        ss1   = rol32(a12 + e_reg + rol32(tj, j_reg[4:0]), 5'd7);
        ss2   = ss1 ^ a12;
        if (j_reg < 6'd16)
        begin
            ff = a_reg ^ b_reg ^ c_reg;
            gg = e_reg ^ f_reg ^ g_reg;
        end
        else
        begin
            ff = (a_reg & b_reg) | (a_reg & c_reg) | (b_reg & c_reg);
            gg = (e_reg & f_reg) | (~e_reg & g_reg);
        end
        tt1 = ff + d_reg + ss2 + (w_reg[0] ^ w_reg[4]);
        tt2 = gg + h_reg + ss1 + w_reg[0];
    end

    assign cv_out = cv_reg ^ {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg};

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= block[511 - 32*i -: 32];
            end
            {a_reg, b_reg, c_reg, d_reg, e_reg, f_reg, g_reg, h_reg} <= cv_in;
            cv_reg <= cv_in;
        end
        else if (busy_reg)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[15] <= w_new;
            d_reg <= c_reg;
            c_reg <= rol32(b_reg, 5'd9);
            b_reg <= a_reg;
            a_reg <= tt1;
            h_reg <= g_reg;
            g_reg <= rol32(f_reg, 5'd19);
            f_reg <= e_reg;
            e_reg <= perm0(tt2);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done     <= 1'b0;
            j_reg    <= '0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                j_reg    <= '0;
            end
            else if (busy_reg)
            begin
                j_reg <= j_reg + 1'b1;
                if (j_reg == 6'd63)
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sm3_back.sv -----
// SM3 back end: block buffer, length count, padding and digest output sequencer.
// Depends on sm3_pkg and sm3_round.
`default_nettype none

module sm3_back
    import sm3_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  q_valid,
    output logic       q_ready,
    input  wire item_t q_item,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic [31:0] out_word,
    output logic       out_last
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PAD,
        ST_RUN,
        ST_EMIT
    } state_t;

    state_t        state_reg;
    logic [511:0]  buf_reg;
    logic [255:0]  cv_reg;
    logic [60:0]   cnt_reg;
    logic [63:0]   bits_reg;
    logic          fin_reg;      // running block belongs to a finish
    logic          second_reg;   // a length-only block still follows
    logic [2:0]    idx_reg;
    logic          start;
    logic          done;
    logic [255:0]  cv_new;
    logic [5:0]    pos;
    logic [511:0]  pad_blk;

    sm3_round u_round
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .block  (buf_reg),
        .cv_in  (cv_reg),
        .done   (done),
        .cv_out (cv_new)
    );

    assign pos      = cnt_reg[5:0] & POS_MASK;
    assign q_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_EMIT);
    assign out_word = cv_reg[255 - 32*idx_reg -: 32];
    assign out_last = (idx_reg == 3'd7);

    // Keep bytes below pos, put 0x80 at pos, zeros above.
    always_comb
    begin
        for (int i = 0; i < 64; i++)
        begin
            if (6'(i) < pos)
            begin
                pad_blk[511 - 8*i -: 8] = buf_reg[511 - 8*i -: 8];
            end
            else if (6'(i) == pos)
            begin
                pad_blk[511 - 8*i -: 8] = PAD_BYTE;
            end
            else
            begin
                pad_blk[511 - 8*i -: 8] = 8'h00;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            cv_reg     <= SM3_IV;
            cnt_reg    <= '0;
            start      <= 1'b0;
            fin_reg    <= 1'b0;
            second_reg <= 1'b0;
            idx_reg    <= '0;
            bits_reg   <= '0;
        end
        else
        begin
            start <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid)
                    begin
                        if (q_item.op == OP_ABSORB)
                        begin
                            buf_reg[511 - 8*pos -: 8] <= q_item.data;
                            cnt_reg <= cnt_reg + 1'b1;
                            if (pos == POS_MASK)
                            begin
                                fin_reg   <= 1'b0;
                                start     <= 1'b1;
                                state_reg <= ST_RUN;
                            end
                        end
                        else
                        begin
                            bits_reg  <= {cnt_reg, 3'b000};
                            state_reg <= ST_PAD;
                        end
                    end
                end
                ST_PAD:
                begin
                    fin_reg <= 1'b1;
                    start   <= 1'b1;
                    state_reg <= ST_RUN;
                    if (pos >= LEN_OFFSET)
                    begin
                        buf_reg    <= pad_blk;
                        second_reg <= 1'b1;
                    end
                    else
                    begin
                        buf_reg    <= {pad_blk[511:64], bits_reg};
                        second_reg <= 1'b0;
                    end
                end
                ST_RUN:
                begin
                    if (done)
                    begin
                        cv_reg <= cv_new;
                        if (!fin_reg)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else if (second_reg)
                        begin
                            second_reg <= 1'b0;
                            buf_reg    <= {448'd0, bits_reg};
                            start      <= 1'b1;
                        end
                        else
                        begin
                            idx_reg   <= '0;
                            state_reg <= ST_EMIT;
                        end
                    end
                end
                ST_EMIT:
                begin
                    if (out_ready)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        if (idx_reg == 3'd7)
                        begin
                            cv_reg    <= SM3_IV;
                            cnt_reg   <= '0;
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- rtl/sm3_hash_engine_core.sv -----
// SM3 hash engine top level: stream ports, input queue and compression back end.
// Depends on sm3_pkg, sm3_front, sm3_back, sm3_round.
//
// Channel  | Dir | tdata                         | tuser          | tlast
// s_axis   | in  | [7:0] message_byte            | [0] operation  | -
// m_axis   | out | [31:0] digest_word            | -              | digest_last
//
// An absorb transfer is taken while the back end is idle; every 64th byte holds
// the back end for a compression (start, block load, 64 rounds one per cycle,
// write-back) before it takes the next byte.
// A finish runs one or two compressions plus a padding step, then emits
// eight words. The four-entry input queue keeps taking transfers meanwhile.
// rst_n clears the queue, length count and chaining value (back to the IV).
// A stalled m_axis holds the current digest word and the back end.
`default_nettype none

module sm3_hash_engine_core
    import sm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = QueueDepth
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] message_byte
    input  wire logic        s_axis_tuser,   // [0] operation
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [31:0] digest_word
    output logic             m_axis_tlast
);

    item_t in_item, q_item;
    logic  q_valid, q_ready;

    assign in_item.op   = op_t'(s_axis_tuser);
    assign in_item.data = s_axis_tdata;

    sm3_front #(.DEPTH(QUEUE_DEPTH)) u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    sm3_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_word  (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking bench for sm3_hash_engine_core: streams bytes and finish
// transfers, predicts each digest in SV and compares all eight words.
// Depends on sm3_pkg and the RTL under rtl.
`timescale 1ns / 1ps

module testbench;
    import sm3_pkg::*;

    localparam int WatchdogLimit = 20000;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic        m_axis_tlast;

    typedef struct packed
    {
        logic [31:0] word;
        logic        last;
    } digest_beat_t;

    item_t          pending_items[$];
    digest_beat_t   digest_queue[$];

    // predictor state
    logic [31:0] chain_words[8];
    logic [7:0]  msg_block[64];
    logic [60:0] msg_bytes;

    int  send_idle_pct;
    int  recv_stall_pct;
    int  hold_off_cycles;
    int  idle_cycles;
    int  error_count;

    sm3_hash_engine_core uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),    // [7:0] message_byte
        .s_axis_tuser  (s_axis_tuser),    // [0] operation
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),    // [31:0] digest_word
        .m_axis_tlast  (m_axis_tlast)
    );

    always #6 clk = ~clk;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        int k;
        begin
            k = n % 32;
            if (k == 0)
                return x;
            return (x << k) | (x >> (32 - k));
        end
    endfunction

    // Run one compression over msg_block and fold it into the chain words.
    task automatic compress_chain();
        logic [31:0] w[68];
        logic [31:0] a, b, c, d, e, f, g, h;
        logic [31:0] tconst, a12, ss1, ss2, ff, gg, tt1, tt2, x;
        begin
            for (int j = 0; j < 16; j++)
                w[j] = {msg_block[4*j], msg_block[4*j+1], msg_block[4*j+2], msg_block[4*j+3]};
            for (int j = 16; j < 68; j++)
            begin
                x = w[j-16] ^ w[j-9] ^ rotl(w[j-3], 15);
                w[j] = x ^ rotl(x, 15) ^ rotl(x, 23) ^ rotl(w[j-13], 7) ^ w[j-6];
            end
            a = chain_words[0]; b = chain_words[1]; c = chain_words[2]; d = chain_words[3];
            e = chain_words[4]; f = chain_words[5]; g = chain_words[6]; h = chain_words[7];
            for (int j = 0; j < 64; j++)
            begin
                tconst = (j < 16) ? T_LOW : T_HIGH;
                a12 = rotl(a, 12);
                ss1 = rotl(a12 + e + rotl(tconst, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ff = a ^ b ^ c;
                    gg = e ^ f ^ g;
                end
                else
                begin
                    ff = (a & b) | (a & c) | (b & c);
                    gg = (e & f) | (~e & g);
                end
                tt1 = ff + d + ss2 + (w[j] ^ w[j+4]);
                tt2 = gg + h + ss1 + w[j];
                d = c; c = rotl(b, 9); b = a; a = tt1;
                h = g; g = rotl(f, 19); f = e;
                e = tt2 ^ rotl(tt2, 9) ^ rotl(tt2, 17);
            end
            chain_words[0] ^= a; chain_words[1] ^= b; chain_words[2] ^= c; chain_words[3] ^= d;
            chain_words[4] ^= e; chain_words[5] ^= f; chain_words[6] ^= g; chain_words[7] ^= h;
        end
    endtask

    task automatic restart_chain();
        begin
            for (int i = 0; i < 8; i++)
                chain_words[i] = SM3_IV[255 - 32*i -: 32];
            msg_bytes = '0;
        end
    endtask

    // Advance the predictor by one accepted transfer; queue digest words on finish.
    task automatic predict_transfer(input item_t it);
        int          fill;
        logic [63:0] bit_len;
        digest_beat_t beat;
        begin
            fill = int'(msg_bytes[5:0]);
            if (it.op == OP_ABSORB)
            begin
                msg_block[fill] = it.data;
                msg_bytes = msg_bytes + 61'd1;
                if (msg_bytes[5:0] == 6'd0)
                    compress_chain();
            end
            else
            begin
                bit_len = {msg_bytes, 3'b000};
                msg_block[fill] = PAD_BYTE;
                for (int i = fill + 1; i < 64; i++)
                    msg_block[i] = 8'h00;
                // padding spills into a second block
                if (fill >= int'(LEN_OFFSET))
                begin
                    compress_chain();
                    for (int i = 0; i < 64; i++)
                        msg_block[i] = 8'h00;
                end
                for (int i = 0; i < 8; i++)
                    msg_block[56 + i] = bit_len[63 - 8*i -: 8];
                compress_chain();
                for (int i = 0; i < 8; i++)
                begin
                    beat.word = chain_words[i];
                    beat.last = (i == 7);
                    digest_queue.push_back(beat);
                end
                restart_chain();
            end
        end
    endtask

    function automatic item_t make_item(input op_t op, input logic [7:0] data);
        item_t it;
        begin
            it.op = op;
            it.data = data;
            return it;
        end
    endfunction

    // Driver: offer the head of the pending queue, change inputs on the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_items[0].data;
                s_axis_tuser  <= pending_items[0].op;
            end
            else
                s_axis_tvalid <= 1'b0;

            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_cycles <= hold_off_cycles - 1;
            end
            else
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Monitor: sample at the rising edge, predict on input transfers, check outputs.
    always @(posedge clk)
    begin
        digest_beat_t want;
        if (rst_n)
        begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (s_axis_tvalid && s_axis_tready)
            begin
                predict_transfer(make_item(op_t'(s_axis_tuser), s_axis_tdata));
                void'(pending_items.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (digest_queue.size() == 0)
                begin
                    $error("unexpected digest word %h", m_axis_tdata);
                    error_count++;
                end
                else
                begin
                    want = digest_queue.pop_front();
                    if (m_axis_tdata !== want.word)
                    begin
                        $error("digest_word expected %h actual %h", want.word, m_axis_tdata);
                        error_count++;
                    end
                    if (m_axis_tlast !== want.last)
                    begin
                        $error("digest_last expected %b actual %b", want.last, m_axis_tlast);
                        error_count++;
                    end
                end
            end
            if (idle_cycles >= WatchdogLimit)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        begin
            while (pending_items.size() > 0 || digest_queue.size() > 0)
                @(posedge clk);
        end
    endtask

    // Queue random message bytes without a finish.
    task automatic queue_bytes(input int len);
        begin
            for (int i = 0; i < len; i++)
                pending_items.push_back(make_item(OP_ABSORB, 8'($urandom_range(255))));
        end
    endtask

    // Queue one message of random bytes followed by a finish.
    task automatic queue_message(input int len);
        begin
            queue_bytes(len);
            pending_items.push_back(make_item(OP_FINISH, 8'($urandom_range(255))));
        end
    endtask

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        m_axis_tready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        idle_cycles = 0;
        error_count = 0;
        restart_chain();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: empty message, "abc", extreme bytes, a finish with data bits set.
        pending_items.push_back(make_item(OP_FINISH, 8'h00));
        pending_items.push_back(make_item(OP_ABSORB, 8'h61));
        pending_items.push_back(make_item(OP_ABSORB, 8'h62));
        pending_items.push_back(make_item(OP_ABSORB, 8'h63));
        pending_items.push_back(make_item(OP_FINISH, 8'hFF));
        pending_items.push_back(make_item(OP_ABSORB, 8'h00));
        pending_items.push_back(make_item(OP_ABSORB, 8'hFF));
        pending_items.push_back(make_item(OP_ABSORB, 8'h55));
        pending_items.push_back(make_item(OP_ABSORB, 8'hAA));
        pending_items.push_back(make_item(OP_FINISH, 8'hA5));
        wait_drained();

        // Pressure: hold off the receiver while a burst of finishes fills the queue.
        hold_off_cycles = 400;
        repeat (6) pending_items.push_back(make_item(OP_FINISH, 8'($urandom_range(255))));
        wait_drained();

        // Random phases: one 120-byte message spans the first three phases, so it
        // crosses a block edge and its finish lands at byte 56 (padding spills over).
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            if (phase < 3)
                queue_bytes(40);
            if (phase == 2)
                pending_items.push_back(make_item(OP_FINISH, 8'($urandom_range(255))));
            if (phase == 3)
                queue_message($urandom_range(0, 8));
            wait_drained();
        end

        // End: let the back end settle, then report.
        repeat (200) @(posedge clk);
        if (error_count == 0 && digest_queue.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
